// ----- rtl/kwm_pkg.sv -----
`timescale 1ns / 1ps

package kwm_pkg;

    localparam int MAX_LISTS    = 16;
    localparam int VALUE_BITS   = 32;
    localparam int IDX_BITS     = $clog2(MAX_LISTS);
    localparam int CNT_BITS     = $clog2(MAX_LISTS + 1);
    localparam int CFG_BITS     = 5;
    localparam int S_DATA_BITS  = ((IDX_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = ((VALUE_BITS + IDX_BITS + 7) / 8) * 8;
    localparam logic [CFG_BITS-1:0] LIST_COUNT_RESET = CFG_BITS'(16);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [IDX_BITS-1:0]   source;
    } t_entry;

    // per-cell control broadcast from the sequencer
    typedef struct packed {
        logic ins;
        logic pop;
        logic occupied;
    } t_cell_ctrl;

    // true if entry a must sit ahead of entry b: signed value, then lower stream
    function automatic logic goes_before(input t_entry a, input t_entry b);
        logic [VALUE_BITS-1:0] ka;
        logic [VALUE_BITS-1:0] kb;
        ka = a.value ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
        kb = b.value ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
        return (ka < kb) || ((ka == kb) && (a.source < b.source));
    endfunction

    function automatic logic [CNT_BITS-1:0] effective_count(input logic [CFG_BITS-1:0] c);
        if (c == '0) begin
            return CNT_BITS'(1);
        end else if (32'(c) > MAX_LISTS) begin
            return CNT_BITS'(MAX_LISTS);
        end else begin
            return CNT_BITS'(c);
        end
    endfunction

endpackage

// ----- rtl/kwm_cell.sv -----
`timescale 1ns / 1ps

module kwm_cell import kwm_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  t_entry     i_left,
    input  logic       i_left_before,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_before
);

    t_entry r_entry;

    // an empty cell always yields to the new entry; on equal values the lower stream index goes first
    assign o_before = !i_ctrl.occupied || goes_before(i_new, r_entry);
    assign o_entry  = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pop) begin
            r_entry <= i_right;
        end else if (i_ctrl.ins && o_before) begin
            r_entry <= i_left_before ? i_left : i_new;
        end
    end

endmodule

// ----- rtl/k_way_sorted_merge_unit.sv -----
`timescale 1ns / 1ps

// K-way sorted merge. Pending stream heads live in a row of MAX_LISTS cells kept in
// ascending order (signed value, then lower stream index); an insert shifts the larger
// entries one cell right, and taking the head shifts the whole row one cell left. An
// answer (s-side transfer: list_index and value in tdata, exhausted flag in tuser) is
// accepted while the unit is in S_ACCEPT. An answer that is not exhausted is inserted
// into the row; once the answer that completes the count is in, S_EMIT loads the output
// register with the smallest head (or the done marker in tuser) and shifts the row.
// S_EMIT waits while the output register holds a result that is not yet taken.
// A list_count write takes effect at the next rearm, after a done marker; reset
// restores LIST_COUNT_RESET. 0 counts as 1 and values above MAX_LISTS count as MAX_LISTS.
module k_way_sorted_merge_unit import kwm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [S_DATA_BITS-1:0] i_s_tdata,   // list_index, element_value, zero fill
    input  logic                   i_s_tuser,   // list_exhausted
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [M_DATA_BITS-1:0] o_m_tdata,   // merged_value, from_list, zero fill
    output logic                   o_m_tuser,   // merge_done
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_BITS-1:0]    i_cfg_data
);

    typedef enum logic {
        S_ACCEPT,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [CNT_BITS-1:0]   r_held;
    logic [CNT_BITS-1:0]   r_awaited;
    logic [CFG_BITS-1:0]   r_list_count;
    logic                  r_m_valid;
    logic [VALUE_BITS-1:0] r_m_value;
    logic [IDX_BITS-1:0]   r_m_from;
    logic                  r_m_done;

    logic                  s_xfer;
    logic                  out_free;
    logic                  emit;
    logic [CNT_BITS-1:0]   n_awaited;
    t_entry                w_new;
    t_entry                w_entry  [MAX_LISTS];
    logic                  w_before [MAX_LISTS];
    t_cell_ctrl            w_ctrl   [MAX_LISTS];

    assign o_s_tready  = (r_state == S_ACCEPT);
    assign o_cfg_ready = 1'b1;
    assign s_xfer      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_m_valid || i_m_tready;
    assign emit        = (r_state == S_EMIT) && out_free;
    assign n_awaited   = r_awaited - CNT_BITS'(1);

    assign w_new.source = i_s_tdata[IDX_BITS-1:0];
    assign w_new.value  = i_s_tdata[IDX_BITS +: VALUE_BITS];

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = M_DATA_BITS'({r_m_from, r_m_value});
    assign o_m_tuser  = r_m_done;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LISTS; gi++) begin : g_cell
            assign w_ctrl[gi].ins      = s_xfer && !i_s_tuser;
            assign w_ctrl[gi].pop      = emit && (r_held != '0);
            assign w_ctrl[gi].occupied = (CNT_BITS'(gi) < r_held);
            if (gi == 0) begin : g_first
                kwm_cell u_cell (
                    .i_clk         (i_clk),
                    .i_ctrl        (w_ctrl[gi]),
                    .i_new         (w_new),
                    .i_left        (w_new),
                    .i_left_before (1'b0),
                    .i_right       (w_entry[gi+1]),
                    .o_entry       (w_entry[gi]),
                    .o_before      (w_before[gi])
                );
            end else if (gi == MAX_LISTS - 1) begin : g_last
                kwm_cell u_cell (
                    .i_clk         (i_clk),
                    .i_ctrl        (w_ctrl[gi]),
                    .i_new         (w_new),
                    .i_left        (w_entry[gi-1]),
                    .i_left_before (w_before[gi-1]),
                    .i_right       (w_entry[gi]),
                    .o_entry       (w_entry[gi]),
                    .o_before      (w_before[gi])
                );
            end else begin : g_mid
                kwm_cell u_cell (
                    .i_clk         (i_clk),
                    .i_ctrl        (w_ctrl[gi]),
                    .i_new         (w_new),
                    .i_left        (w_entry[gi-1]),
                    .i_left_before (w_before[gi-1]),
                    .i_right       (w_entry[gi+1]),
                    .o_entry       (w_entry[gi]),
                    .o_before      (w_before[gi])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_count <= LIST_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_list_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ACCEPT;
            r_held    <= '0;
            r_awaited <= effective_count(LIST_COUNT_RESET);
            r_m_valid <= 1'b0;
        end else begin
            // drop a taken result unless a new one loads in its place
            if (r_m_valid && i_m_tready && !emit) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_ACCEPT: begin
                    if (s_xfer) begin
                        if (!i_s_tuser) begin
                            r_held <= r_held + CNT_BITS'(1);
                        end
                        r_awaited <= n_awaited;
                        if (n_awaited == '0) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        if (r_held != '0) begin
                            // hand out the head; its stream answers next
                            r_m_value <= w_entry[0].value;
                            r_m_from  <= w_entry[0].source;
                            r_m_done  <= 1'b0;
                            r_held    <= r_held - CNT_BITS'(1);
                            r_awaited <= CNT_BITS'(1);
                        end else begin
                            // store drained: mark the end and rearm
                            r_m_value <= '0;
                            r_m_from  <= '0;
                            r_m_done  <= 1'b1;
                            r_awaited <= effective_count(r_list_count);
                        end
                        r_state <= S_ACCEPT;
                    end
                end
                default: begin
                    r_state <= S_ACCEPT;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= MAX_LISTS)
        else $error("held count above cell count");

    a_emit_none_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_awaited == '0))
        else $error("result stage entered with answers outstanding");

    a_accept_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACCEPT) |-> (r_awaited != '0))
        else $error("accepting with no answer outstanding");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && !i_s_tuser) |=> (r_held == $past(r_held) + CNT_BITS'(1)))
        else $error("insert did not grow the row");

    a_done_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (r_held == '0)) |=> (r_m_done && (r_m_value == '0) && (r_m_from == '0)))
        else $error("done marker carries data");
`endif

endmodule
